[hdl/sims_pkg.sv]
package sims_pkg;

   localparam int OPERATION_W = 2;
   localparam int ION_MASS_W = 13;
   localparam int INTENSITY_W = 16;
   localparam int SCORE_W = 24;
   localparam int COUNT_W = 10;

   // mass plus one spare bit so that the upper neighbor of the top mass fits
   localparam int BIN_W = ION_MASS_W + 1;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [OPERATION_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_START = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_SCORE = 2'd2;

   localparam logic [1:0] PHASE_EXACT = 2'd0;
   localparam logic [1:0] PHASE_LOWER = 2'd1;
   localparam logic [1:0] PHASE_UPPER = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [OPERATION_W-1:0] operation;
      logic [ION_MASS_W-1:0] ion_mass;
      logic [INTENSITY_W-1:0] intensity;
      logic last_ion;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_START,
      CMD_SCORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic bin_ok;
      logic [ION_MASS_W-1:0] ion_mass;
      logic [INTENSITY_W-1:0] intensity;
      logic last_ion;
   } entry_type;

   typedef enum logic [1:0] {
      BACK_INIT,
      BACK_READY,
      BACK_SCORE,
      BACK_WIPE
   } back_state_type;

endpackage

[hdl/sims_front.sv]
module sims_front #(
   parameter int MASS_BINS = 8192
) (
   input logic start,
   input sims_pkg::req_type req_data,
   input logic queue_full,
   output logic busy,
   output logic push,
   output sims_pkg::entry_type push_entry
);
   import sims_pkg::*;

   logic [31:0] mass_wide;
   logic accept;

   assign busy = queue_full;
   assign accept = start && !queue_full;
   assign mass_wide = 32'(req_data.ion_mass);

   always_comb begin
      push_entry.kind = CMD_LOAD;
      push_entry.bin_ok = mass_wide < 32'(MASS_BINS);
      push_entry.ion_mass = req_data.ion_mass;
      push_entry.intensity = req_data.intensity;
      push_entry.last_ion = req_data.last_ion;
      push = 1'b0;
      unique case (req_data.operation)
         OP_LOAD: begin
            push_entry.kind = CMD_LOAD;
            push = accept;
         end
         OP_START: begin
            push_entry.kind = CMD_START;
            push = accept;
         end
         OP_SCORE: begin
            push_entry.kind = CMD_SCORE;
            push = accept;
         end
         // unknown operation is taken and dropped
         default: push = 1'b0;
      endcase
   end

endmodule

[hdl/sims_queue.sv]
module sims_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input sims_pkg::entry_type push_entry,
   input logic pop,
   output logic full,
   output logic valid,
   output sims_pkg::entry_type head
);
   import sims_pkg::*;

   entry_type slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign full = count_ff == Q_CNT_W'(Q_DEPTH);
   assign valid = count_ff != '0;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/sims_back.sv]
module sims_back #(
   parameter int MASS_BINS = 8192,
   parameter int INTENSITY_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input sims_pkg::entry_type q_entry,
   output logic q_pop,
   output logic rsp_strobe,
   output sims_pkg::rsp_type rsp_data
);
   import sims_pkg::*;

   localparam int AW = $clog2(MASS_BINS);
   localparam int SW = (INTENSITY_BITS < INTENSITY_W) ? INTENSITY_BITS : INTENSITY_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MASS_BINS - 1);

   logic [SW-1:0] spec_mem [MASS_BINS];
   logic [SW-1:0] used_mem [MASS_BINS];
   logic [SW-1:0] spec_rd_ff;
   logic [SW-1:0] used_rd_ff;

   back_state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [1:0] phase_ff, phase_in;
   logic [ION_MASS_W-1:0] mass_ff, mass_in;
   logic last_ff, last_in;

   logic issue_en;
   logic [ION_MASS_W-1:0] issue_mass;
   logic [1:0] issue_phase;
   logic issue_last;
   logic [BIN_W-1:0] issue_bin;
   logic [31:0] issue_wide;
   logic [AW-1:0] issue_addr;
   logic issue_ok;

   logic [31:0] load_wide;
   logic spec_we;
   logic [AW-1:0] spec_wa;
   logic [SW-1:0] spec_wd;
   logic used_clear;
   logic used_we;
   logic [AW-1:0] used_wa;
   logic [SW-1:0] used_wd;
   logic sums_clear;

   logic s2_valid_ff;
   logic s2_ok_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [1:0] s2_phase_ff;
   logic s2_emit_ff;
   logic s2_hit_ff;
   logic [SW-1:0] s2_fwd_ff;

   logic [SW-1:0] found;
   logic [SW-1:0] used_val;
   logic gain_ok;
   logic [SW-1:0] gain;
   logic [SCORE_W:0] sum_wide;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic rsp_strobe_ff;
   rsp_type rsp_data_ff;

   assign load_wide = 32'(q_entry.ion_mass);

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      phase_in = phase_ff;
      mass_in = mass_ff;
      last_in = last_ff;
      q_pop = 1'b0;
      issue_en = 1'b0;
      issue_mass = mass_ff;
      issue_phase = phase_ff;
      issue_last = last_ff;
      spec_we = 1'b0;
      spec_wa = load_wide[AW-1:0];
      spec_wd = q_entry.intensity[SW-1:0];
      used_clear = 1'b0;
      sums_clear = 1'b0;
      unique case (state_ff)
         BACK_INIT: begin
            // clearing pass over both stores after reset
            spec_we = 1'b1;
            spec_wa = sweep_ff;
            spec_wd = '0;
            used_clear = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = BACK_READY;
            end
         end
         BACK_READY: begin
            if (q_valid) begin
               unique case (q_entry.kind)
                  CMD_LOAD: begin
                     q_pop = 1'b1;
                     spec_we = q_entry.bin_ok;
                  end
                  CMD_START: begin
                     // wait until the last bin write has landed
                     if (!s2_valid_ff) begin
                        q_pop = 1'b1;
                        sums_clear = 1'b1;
                        state_in = BACK_WIPE;
                     end
                  end
                  CMD_SCORE: begin
                     q_pop = 1'b1;
                     issue_en = 1'b1;
                     issue_mass = q_entry.ion_mass;
                     issue_phase = PHASE_EXACT;
                     issue_last = q_entry.last_ion;
                     mass_in = q_entry.ion_mass;
                     last_in = q_entry.last_ion;
                     phase_in = PHASE_LOWER;
                     state_in = BACK_SCORE;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BACK_SCORE: begin
            issue_en = 1'b1;
            if (phase_ff == PHASE_LOWER) begin
               phase_in = PHASE_UPPER;
            end else begin
               phase_in = PHASE_EXACT;
               state_in = BACK_READY;
            end
         end
         BACK_WIPE: begin
            used_clear = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = BACK_READY;
            end
         end
      endcase
   end

   always_comb begin
      unique case (issue_phase)
         PHASE_LOWER: issue_bin = {1'b0, issue_mass} - 1'b1;
         PHASE_UPPER: issue_bin = {1'b0, issue_mass} + 1'b1;
         default: issue_bin = {1'b0, issue_mass};
      endcase
      issue_wide = 32'(issue_bin);
      issue_addr = issue_wide[AW-1:0];
      issue_ok = !(issue_phase == PHASE_LOWER && issue_mass == '0)
         && issue_wide < 32'(MASS_BINS);
   end

   // bin compare and update on registered read data
   always_comb begin
      found = (s2_phase_ff == PHASE_EXACT) ? spec_rd_ff : spec_rd_ff >> 1;
      used_val = s2_hit_ff ? s2_fwd_ff : used_rd_ff;
      gain_ok = s2_valid_ff && s2_ok_ff && (found > used_val);
      gain = found - used_val;
      sum_wide = (SCORE_W + 1)'(score_ff) + (SCORE_W + 1)'(gain);
      score_in = score_ff;
      count_in = count_ff;
      if (gain_ok) begin
         score_in = sum_wide[SCORE_W] ? '1 : sum_wide[SCORE_W-1:0];
         if (s2_phase_ff == PHASE_EXACT && count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end
      used_we = used_clear || gain_ok;
      used_wa = used_clear ? sweep_ff : s2_addr_ff;
      used_wd = used_clear ? '0 : found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_INIT;
         sweep_ff <= '0;
         phase_ff <= PHASE_EXACT;
         s2_valid_ff <= 1'b0;
         score_ff <= '0;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         phase_ff <= phase_in;
         s2_valid_ff <= issue_en;
         if (sums_clear) begin
            score_ff <= '0;
            count_ff <= '0;
         end else begin
            score_ff <= score_in;
            count_ff <= count_in;
         end
         rsp_strobe_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      mass_ff <= mass_in;
      last_ff <= last_in;
      s2_ok_ff <= issue_ok;
      s2_addr_ff <= issue_addr;
      s2_phase_ff <= issue_phase;
      s2_emit_ff <= (issue_phase == PHASE_UPPER) && issue_last;
      // a write landing at the same edge as the read is forwarded
      s2_hit_ff <= used_we && (used_wa == issue_addr);
      s2_fwd_ff <= used_wd;
      rsp_data_ff.score <= score_in;
      rsp_data_ff.match_count <= count_in;
   end

   always_ff @(posedge clock) begin
      if (spec_we) begin
         spec_mem[spec_wa] <= spec_wd;
      end
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      spec_rd_ff <= spec_mem[issue_addr];
      used_rd_ff <= used_mem[issue_addr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

endmodule

[hdl/spectrum_ion_match_scorer_core.sv]
// Fragment ion scorer against a dense spectrum held in block memory. A request is taken when
// start is high and busy is low; busy rises only while the two-entry request queue is full.
// A load is written from the queue head into the spectrum store, a scored ion reads bins m,
// m-1 and m+1 in that order (each read overlapped with the update of the bin before it, so a
// new ion's reads can overlap the last ion's final update), and a start waits for the last bin
// update to finish and then clears the used store. After reset a clearing pass zeroes both
// stores before the first request is carried out; requests may queue up meanwhile. The result
// of an ion marked last appears on rsp_data for exactly one cycle with rsp_strobe, registered
// from the update of its third bin; the receiver cannot stall it.
module spectrum_ion_match_scorer_core #(
   parameter int MASS_BINS = 8192,
   parameter int INTENSITY_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input sims_pkg::req_type req_data,
   output logic busy,
   output logic rsp_strobe,
   output sims_pkg::rsp_type rsp_data
);
   import sims_pkg::*;

   logic queue_full;
   logic push;
   entry_type push_entry;
   logic pop;
   logic q_valid;
   entry_type q_head;

   sims_front #(
      .MASS_BINS(MASS_BINS)
   ) u_front (
      .start(start),
      .req_data(req_data),
      .queue_full(queue_full),
      .busy(busy),
      .push(push),
      .push_entry(push_entry)
   );

   sims_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .full(queue_full),
      .valid(q_valid),
      .head(q_head)
   );

   sims_back #(
      .MASS_BINS(MASS_BINS),
      .INTENSITY_BITS(INTENSITY_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_entry(q_head),
      .q_pop(pop),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule

[tb/sv/spectrum_ion_match_scorer_checker.sv]
`timescale 1ns / 100ps
module spectrum_ion_match_scorer_checker
   import sims_pkg::*;
#(
   parameter int MASS_BINS = 8192
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input req_type req_data,
   input logic rsp_strobe,
   input rsp_type rsp_data,
   output int fail_count,
   output int pending
);

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   logic [INTENSITY_W-1:0] peak_bins [MASS_BINS];
   logic [INTENSITY_W-1:0] used_bins [MASS_BINS];
   logic [SCORE_W-1:0] score_acc;
   logic [COUNT_W-1:0] hit_count;
   rsp_type pending_scores [$];

   // raise one bin's used value to what it holds now, adding the gain to the score
   function automatic logic take_bin_gain(input int bin, input logic half);
      logic [INTENSITY_W-1:0] found;
      logic [SCORE_W:0] total;
      if (bin < 0 || bin >= MASS_BINS) return 1'b0;
      found = half ? (peak_bins[bin] >> 1) : peak_bins[bin];
      if (used_bins[bin] >= found) return 1'b0;
      total = {1'b0, score_acc} + (SCORE_W + 1)'(found - used_bins[bin]);
      used_bins[bin] = found;
      score_acc = (total > {1'b0, SCORE_MAX}) ? SCORE_MAX : total[SCORE_W-1:0];
      return 1'b1;
   endfunction

   task automatic predict_request(input req_type r);
      rsp_type res;
      logic exact_gain;
      case (r.operation)
         OP_LOAD: begin
            if (int'(r.ion_mass) < MASS_BINS) peak_bins[r.ion_mass] = r.intensity;
         end
         OP_START: begin
            for (int i = 0; i < MASS_BINS; i++) used_bins[i] = '0;
            score_acc = '0;
            hit_count = '0;
         end
         OP_SCORE: begin
            exact_gain = take_bin_gain(int'(r.ion_mass), 1'b0);
            if (exact_gain && hit_count != COUNT_MAX) hit_count = hit_count + 1'b1;
            void'(take_bin_gain(int'(r.ion_mass) - 1, 1'b1));
            void'(take_bin_gain(int'(r.ion_mass) + 1, 1'b1));
            if (r.last_ion) begin
               res.score = score_acc;
               res.match_count = hit_count;
               pending_scores = {pending_scores, res};
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MASS_BINS; i++) begin
            peak_bins[i] = '0;
            used_bins[i] = '0;
         end
         score_acc = '0;
         hit_count = '0;
         pending_scores.delete();
         fail_count = 0;
      end else begin
         // a result always belongs to an ion taken earlier, so compare first
         if (rsp_strobe) begin
            if (pending_scores.size() == 0) begin
               $display("%0t unexpected result: expected none actual score %0d match_count %0d",
                        $time, rsp_data.score, rsp_data.match_count);
               fail_count++;
            end else begin
               want = pending_scores.pop_front();
               if (rsp_data.score !== want.score) begin
                  $display("%0t score mismatch: expected %0d actual %0d",
                           $time, want.score, rsp_data.score);
                  fail_count++;
               end
               if (rsp_data.match_count !== want.match_count) begin
                  $display("%0t match_count mismatch: expected %0d actual %0d",
                           $time, want.match_count, rsp_data.match_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) predict_request(req_data);
      end
      pending = pending_scores.size();
   end

endmodule

[tb/sv/tb_spectrum_ion_match_scorer_core.sv]
`timescale 1ns / 100ps
module tb_spectrum_ion_match_scorer_core;
   import sims_pkg::*;

   localparam int MASS_BINS = 8192;
   localparam int TOP_MASS = MASS_BINS - 1;
   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 40000;
   localparam int RANDOM_ITEMS = 650;
   localparam int DENSE_BINS = 300;
   localparam int DENSE_BASE = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy;
   logic rsp_strobe;
   rsp_type rsp_data;
   int fail_count;
   int pending;
   int sent_count = 0;
   int stall_cycles = 0;
   logic idle_en = 1'b1;

   always #1 clock = ~clock;

   spectrum_ion_match_scorer_core #(
      .MASS_BINS(MASS_BINS),
      .INTENSITY_BITS(INTENSITY_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   spectrum_ion_match_scorer_checker #(
      .MASS_BINS(MASS_BINS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("spectrum_ion_match_scorer_core regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_req(input int op, input int mass, input int inten,
                                        input int last);
      req_type r;
      r.operation = op[OPERATION_W-1:0];
      r.ion_mass = mass[ION_MASS_W-1:0];
      r.intensity = inten[INTENSITY_W-1:0];
      r.last_ion = last[0];
      return r;
   endfunction

   function automatic int rand_intensity();
      int p;
      p = int'($urandom_range(0, 99));
      if (p < 25) return 65535;
      if (p < 35) return 0;
      if (p < 45) return int'($urandom_range(1, 3));
      return int'($urandom_range(0, 65535));
   endfunction

   // ion mass inside a peak window, reaching one bin past either end
   function automatic int near_mass(input int base);
      int mm;
      mm = base + int'($urandom_range(0, 33)) - 1;
      if (mm < 0) mm = 0;
      if (mm > TOP_MASS) mm = TOP_MASS;
      return mm;
   endfunction

   task automatic issue(input req_type r);
      int gap;
      gap = 0;
      if (idle_en && $urandom_range(0, 99) < 20) gap = int'($urandom_range(1, 5));
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
         req_data <= req_type'($urandom);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.operation != OP_UNUSED) sent_count++;
   endtask

   initial begin
      int base;
      int n;
      int pick;
      int op;
      int random_stop;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edges of the store, ignored last flags, repeat and raised peaks
      issue(make_req(OP_UNUSED, TOP_MASS, 65535, 1));
      issue(make_req(OP_LOAD, 0, 65535, 1));
      issue(make_req(OP_LOAD, 1, 1, 0));
      issue(make_req(OP_LOAD, TOP_MASS, 65535, 0));
      issue(make_req(OP_LOAD, TOP_MASS - 1, 3, 0));
      issue(make_req(OP_LOAD, 101, 16'h8001, 0));
      issue(make_req(OP_LOAD, 102, 16'h5555, 0));
      issue(make_req(OP_LOAD, 100, 0, 0));
      issue(make_req(OP_START, TOP_MASS, 65535, 1));
      issue(make_req(OP_SCORE, 0, 65535, 0));
      issue(make_req(OP_SCORE, TOP_MASS, 0, 1));
      issue(make_req(OP_SCORE, 100, 0, 1));
      issue(make_req(OP_SCORE, 100, 0, 1));
      issue(make_req(OP_SCORE, 102, 0, 1));
      issue(make_req(OP_LOAD, 101, 65535, 0));
      issue(make_req(OP_SCORE, 101, 0, 1));
      issue(make_req(OP_UNUSED, 101, 0, 0));
      issue(make_req(OP_SCORE, 1, 65535, 1));
      issue(make_req(OP_START, 0, 0, 0));
      issue(make_req(OP_SCORE, TOP_MASS - 1, 0, 1));

      // dense run of strong peaks drives the score into saturation
      issue(make_req(OP_START, 0, 0, 0));
      for (int k = 0; k < DENSE_BINS; k++)
         issue(make_req(OP_LOAD, DENSE_BASE + k, int'($urandom_range(60000, 65535)), 0));
      for (int k = 0; k < DENSE_BINS; k++)
         issue(make_req(OP_SCORE, DENSE_BASE + k, int'($urandom_range(0, 65535)),
                        int'((k % 128 == 127) || (k == DENSE_BINS - 1))));

      random_stop = sent_count + RANDOM_ITEMS;
      base = 0;
      while (sent_count < random_stop) begin
         idle_en = !((sent_count - random_stop + RANDOM_ITEMS) >= 400 &&
                     (sent_count - random_stop + RANDOM_ITEMS) < 700);
         pick = int'($urandom_range(0, 99));
         if (pick < 10) base = 0;
         else if (pick < 20) base = MASS_BINS - 32;
         else base = int'($urandom_range(0, MASS_BINS - 32));
         pick = int'($urandom_range(0, 99));
         if (pick < 75) begin
            // peptide: peaks in a window, start, ions over the window
            n = int'($urandom_range(0, 12));
            repeat (n)
               issue(make_req(OP_LOAD, base + int'($urandom_range(0, 31)), rand_intensity(),
                              int'($urandom_range(0, 1))));
            issue(make_req(OP_START, int'($urandom_range(0, TOP_MASS)),
                           int'($urandom_range(0, 65535)), int'($urandom_range(0, 1))));
            n = int'($urandom_range(1, 24));
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0)
                  issue(make_req(OP_LOAD, base + int'($urandom_range(0, 31)), rand_intensity(),
                                 0));
               issue(make_req(OP_SCORE, near_mass(base), int'($urandom_range(0, 65535)),
                              int'((k == n - 1) || ($urandom_range(0, 9) == 0))));
            end
         end else if (pick < 87) begin
            // noise of any operation, starts kept rare since each clears the whole used store
            repeat ($urandom_range(1, 4)) begin
               op = int'($urandom_range(0, 3));
               if (op == int'(OP_START) && $urandom_range(0, 3) != 0) op = int'(OP_UNUSED);
               issue(make_req(op, int'($urandom_range(0, TOP_MASS)),
                              int'($urandom_range(0, 65535)), int'($urandom_range(0, 1))));
            end
         end else begin
            // ions with no start, carrying on from the previous sums
            n = int'($urandom_range(1, 8));
            for (int k = 0; k < n; k++)
               issue(make_req(OP_SCORE, near_mass(base), int'($urandom_range(0, 65535)),
                              int'((k == n - 1) && ($urandom_range(0, 1) == 1))));
         end
      end
      issue(make_req(OP_SCORE, near_mass(base), 0, 1));

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("spectrum_ion_match_scorer_core regression: pass");
      end else begin
         $display("spectrum_ion_match_scorer_core regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/sims_pkg.sv
hdl/sims_front.sv
hdl/sims_queue.sv
hdl/sims_back.sv
hdl/spectrum_ion_match_scorer_core.sv
tb/sv/spectrum_ion_match_scorer_checker.sv
tb/sv/tb_spectrum_ion_match_scorer_core.sv
